// File: hw/rtl/calibration_curve_interpolator_unit_macros.svh
// Assertion macros for the calibration curve interpolator.
// Included by the top level; depends on nothing else.
`ifndef CALIBRATION_CURVE_INTERPOLATOR_UNIT_MACROS_SVH
`define CALIBRATION_CURVE_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CCINT_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCINT_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ccint_pkg.sv
// Shared constants, types and helpers for the calibration curve interpolator.
// No dependencies; imported by the interpolator top level and ccint_div.
package ccint_pkg;

    localparam int MAX_POINTS = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int KIND_W  = 2;
    localparam int ENTRY_W = 5;
    localparam int DATA_W  = 32;
    localparam int SEG_W   = 5;
    localparam int FRAC_W  = 16;
    localparam int PC_W    = 6;
    localparam int FMT_W   = 3;
    localparam int PCX_W   = (PC_W > CNT_W) ? PC_W : CNT_W;

    localparam int IN_TDATA_W  = ((ENTRY_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = DATA_W + SEG_W + FRAC_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_BP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_CELL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP    = 2'd2;

    // cell formats
    localparam logic [FMT_W-1:0] FMT_Q16 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_U8  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_U16 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_S8  = 3'd3;
    localparam logic [FMT_W-1:0] FMT_S16 = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_FORMAT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE      = 3'd4;

    localparam logic [PC_W-1:0]          RST_POINT_COUNT   = 6'd2;
    localparam logic [FMT_W-1:0]         RST_CELL_FORMAT   = FMT_Q16;
    localparam logic signed [DATA_W-1:0] RST_RESULT_SCALE  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_RESULT_OFFSET = 32'sd0;

    localparam logic signed [DATA_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] numer;
        logic [DATA_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } div_rsp_t;

    // stored cell bits to Q16.16, one bit of headroom for u16
    function automatic logic signed [DATA_W:0] cell_value(
        input logic [DATA_W-1:0] raw,
        input logic [FMT_W-1:0]  fmt
    );
        logic signed [DATA_W:0] v;
        unique case (fmt)
            FMT_U8:  v = signed'({9'b0, raw[7:0], 16'b0});
            FMT_U16: v = signed'({1'b0, raw[15:0], 16'b0});
            FMT_S8:  v = signed'({{9{raw[7]}}, raw[7:0], 16'b0});
            FMT_S16: v = signed'({raw[15], raw[15:0], 16'b0});
            default: v = signed'({raw[DATA_W-1], raw});
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/calibration_curve_interpolator_unit.sv
// Calibration curve interpolator: breakpoint and cell tables in two RAMs.
// After accept: loads and no-ops go straight out; a lookup checks the last breakpoint (clamp high), the
// first (clamp low), else searches, divides (16 quotient bits), reads cells, two multiplies.
// One item at a time: next item accepted the cycle after a result enters the output register.
// Reset (async, active low) clears control and config; tables hold garbage until loaded,
// no clearing pass. Depends on ccint_pkg, ccint_ram, ccint_div.
`include "calibration_curve_interpolator_unit_macros.svh"

module calibration_curve_interpolator_unit
    import ccint_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // entry_index, operand, zero pad
    input  logic [KIND_W-1:0]      s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // result, segment, fraction, zero pad
    output logic [0:0]             m_tuser    // saturated
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_LAST,
        S_CHK_FIRST,
        S_SEARCH,
        S_DIV,
        S_CELL0,
        S_CELL1,
        S_CELL2,
        S_MUL1,
        S_INTERP,
        S_MUL2,
        S_FIN,
        S_EMIT
    } state_t;

    localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELD_W;

    // configuration
    logic [PC_W-1:0]          point_count_reg;
    logic [FMT_W-1:0]         cell_format_reg;
    logic signed [DATA_W-1:0] scale_reg;
    logic signed [DATA_W-1:0] offset_reg;
    logic                     raw_mode_reg;

    state_t                   state_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;
    logic                     m_tuser_reg;

    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] lo_reg;
    logic [IDX_W-1:0]         seg_reg;
    logic [FRAC_W-1:0]        frac_reg;
    logic signed [DATA_W:0]   v0_reg;
    logic signed [DATA_W:0]   v1_reg;
    logic signed [50:0]       prod1_reg;
    logic signed [DATA_W:0]   interp_reg;
    logic signed [64:0]       prod2_reg;
    logic [DATA_W-1:0]        res_reg;
    logic                     sat_reg;

    // input unpacking
    logic [KIND_W-1:0]        in_kind;
    logic [ENTRY_W-1:0]       in_entry;
    logic [DATA_W-1:0]        in_operand;
    logic                     in_accept;
    logic                     entry_ok;

    // table access
    logic                     bp_we;
    logic                     cell_we;
    logic [IDX_W-1:0]         bp_raddr;
    logic [IDX_W-1:0]         cell_raddr;
    logic [DATA_W-1:0]        bp_rdata;
    logic [DATA_W-1:0]        cell_rdata;
    logic signed [DATA_W-1:0] bp_s;

    logic [PCX_W-1:0]         pc_ext;
    logic [CNT_W-1:0]         n_cnt;
    logic [IDX_W-1:0]         last_idx;
    logic [IDX_W-1:0]         upper_idx;
    logic                     found;
    logic                     more;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    // arithmetic
    logic signed [16:0]       frac_s;
    logic signed [33:0]       diff;
    logic signed [50:0]       prod1;
    logic signed [34:0]       interp_sum;
    logic signed [64:0]       prod2;
    logic signed [49:0]       scaled_sum;
    logic signed [16:0]       int_floor;
    logic                     round_up;
    logic [16:0]              int_part;
    logic [DATA_W-1:0]        res_fin;
    logic                     sat_fin;
    logic                     fmt_int;

    assign in_kind    = s_tuser;
    assign in_entry   = s_tdata[ENTRY_W-1:0];
    assign in_operand = s_tdata[ENTRY_W +: DATA_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign entry_ok   = (int'(in_entry) < MAX_POINTS);
    assign bp_we      = in_accept && (in_kind == KIND_LOAD_BP) && entry_ok;
    assign cell_we    = in_accept && (in_kind == KIND_LOAD_CELL) && entry_ok;

    // point count 0 acts as 1, above the table depth as the depth
    assign pc_ext = PCX_W'(point_count_reg);
    always_comb
    begin
        if (pc_ext == '0)
        begin
            n_cnt = CNT_W'(1);
        end
        else if (pc_ext > PCX_W'(MAX_POINTS))
        begin
            n_cnt = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_cnt = CNT_W'(pc_ext);
        end
    end

    assign last_idx  = IDX_W'(n_cnt - CNT_W'(1));
    assign upper_idx = ((CNT_W'(seg_reg) + CNT_W'(1)) < n_cnt) ? seg_reg + IDX_W'(1) : seg_reg;
    assign bp_s      = signed'(bp_rdata);
    assign found     = (lo_reg <= x_reg) && (x_reg < bp_s);
    assign more      = (CNT_W'(seg_reg) + CNT_W'(2)) < n_cnt;

    always_comb
    begin
        bp_raddr      = '0;
        cell_raddr    = '0;
        div_req.start = 1'b0;
        div_req.numer = DATA_W'(x_reg - lo_reg);
        div_req.denom = DATA_W'(bp_s - lo_reg);
        unique case (state_reg)
            S_IDLE:      bp_raddr = last_idx;
            S_CHK_LAST:  bp_raddr = '0;
            S_CHK_FIRST: bp_raddr = IDX_W'(1);
            S_SEARCH:
            begin
                bp_raddr      = seg_reg + IDX_W'(2);
                div_req.start = found;
            end
            S_CELL0:     cell_raddr = seg_reg;
            S_CELL1:     cell_raddr = upper_idx;
            default:     ;
        endcase
    end

    ccint_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_bp_ram (
        .clk   (clk),
        .we    (bp_we),
        .waddr (IDX_W'(in_entry)),
        .wdata (in_operand),
        .raddr (bp_raddr),
        .rdata (bp_rdata)
    );

    ccint_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (IDX_W'(in_entry)),
        .wdata (in_operand),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    ccint_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // interpolation datapath, one multiply per state
    assign frac_s     = signed'({1'b0, frac_reg});
    assign diff       = 34'(v1_reg) - 34'(v0_reg);
    assign prod1      = 51'(frac_s) * 51'(diff);
    assign interp_sum = 35'(v0_reg) + 35'(prod1_reg >>> 16);
    assign prod2      = 65'(scale_reg) * 65'(interp_reg);
    assign scaled_sum = 50'(prod2_reg >>> 16) + 50'(offset_reg);

    // raw mode truncates toward zero
    assign int_floor = 17'(interp_reg >>> 16);
    assign round_up  = interp_reg[DATA_W] && (interp_reg[15:0] != '0);
    assign int_part  = int_floor + {16'b0, round_up};

    assign fmt_int = (cell_format_reg == FMT_U8) || (cell_format_reg == FMT_U16) ||
                     (cell_format_reg == FMT_S8) || (cell_format_reg == FMT_S16);

    always_comb
    begin
        res_fin = interp_reg[DATA_W-1:0];
        sat_fin = 1'b0;
        if (raw_mode_reg)
        begin
            unique case (cell_format_reg)
                FMT_U8:  res_fin = {24'b0, int_part[7:0]};
                FMT_U16: res_fin = {16'b0, int_part[15:0]};
                FMT_S8:  res_fin = {{24{int_part[7]}}, int_part[7:0]};
                FMT_S16: res_fin = {{16{int_part[15]}}, int_part[15:0]};
                default: res_fin = {{15{int_part[16]}}, int_part};
            endcase
        end
        else if (fmt_int)
        begin
            priority if (scaled_sum > 50'(INT32_MAX))
            begin
                res_fin = INT32_MAX;
                sat_fin = 1'b1;
            end
            else if (scaled_sum < 50'(INT32_MIN))
            begin
                res_fin = INT32_MIN;
                sat_fin = 1'b1;
            end
            else
            begin
                res_fin = DATA_W'(scaled_sum);
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= RST_POINT_COUNT;
            cell_format_reg <= RST_CELL_FORMAT;
            scale_reg       <= RST_RESULT_SCALE;
            offset_reg      <= RST_RESULT_OFFSET;
            raw_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_COUNT:   point_count_reg <= cfg_data[PC_W-1:0];
                REG_CELL_FORMAT:   cell_format_reg <= cfg_data[FMT_W-1:0];
                REG_RESULT_SCALE:  scale_reg       <= signed'(cfg_data);
                REG_RESULT_OFFSET: offset_reg      <= signed'(cfg_data);
                REG_RAW_MODE:      raw_mode_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_EMIT) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= (in_kind == KIND_LOOKUP) ? S_CHK_LAST : S_EMIT;
                    end
                end
                S_CHK_LAST:  state_reg <= (x_reg < bp_s) ? S_CHK_FIRST : S_CELL0;
                S_CHK_FIRST: state_reg <= (x_reg < bp_s) ? S_CELL0 : S_SEARCH;
                S_SEARCH:
                begin
                    if (found)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (!more)
                    begin
                        state_reg <= S_CELL0;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_CELL0;
                    end
                end
                S_CELL0:  state_reg <= S_CELL1;
                S_CELL1:  state_reg <= S_CELL2;
                S_CELL2:  state_reg <= S_MUL1;
                S_MUL1:   state_reg <= S_INTERP;
                S_INTERP: state_reg <= S_MUL2;
                S_MUL2:   state_reg <= S_FIN;
                S_FIN:    state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                x_reg    <= signed'(in_operand);
                seg_reg  <= '0;
                frac_reg <= '0;
                res_reg  <= '0;
                sat_reg  <= 1'b0;
            end
            S_CHK_LAST:
            begin
                if (!(x_reg < bp_s))
                begin
                    seg_reg <= last_idx;
                end
            end
            S_CHK_FIRST:
            begin
                lo_reg <= bp_s;
            end
            S_SEARCH:
            begin
                if (!found)
                begin
                    seg_reg <= seg_reg + IDX_W'(1);
                    lo_reg  <= bp_s;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    frac_reg <= div_rsp.quot;
                end
            end
            S_CELL1:  v0_reg     <= cell_value(cell_rdata, cell_format_reg);
            S_CELL2:  v1_reg     <= cell_value(cell_rdata, cell_format_reg);
            S_MUL1:   prod1_reg  <= prod1;
            S_INTERP: interp_reg <= 33'(interp_sum);
            S_MUL2:   prod2_reg  <= prod2;
            S_FIN:
            begin
                res_reg <= res_fin;
                sat_reg <= sat_fin;
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_reg <= {{OUT_PAD_W{1'b0}}, frac_reg, SEG_W'(seg_reg), res_reg};
                    m_tuser_reg <= sat_reg;
                end
            end
            default:  ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CCINT_ASSERT_IMPL(a_sat_only_scaled, clk, rst_n, m_tvalid && m_tuser[0],
        !raw_mode_reg && fmt_int, "saturation flagged outside scaled integer mode")
    `CCINT_ASSERT_IMPL(a_search_in_range, clk, rst_n, state_reg == S_SEARCH,
        (CNT_W'(seg_reg) + CNT_W'(1)) < n_cnt, "search ran past last segment")
    `CCINT_ASSERT_IMPL(a_div_done_waited, clk, rst_n, div_rsp.done,
        state_reg == S_DIV, "divider finished with no lookup waiting")
    `CCINT_ASSERT_NEXT(a_emit_valid, clk, rst_n, state_reg == S_EMIT && (!m_tvalid || m_tready),
        m_tvalid && state_reg == S_IDLE, "emitted item not presented")

endmodule

// File: hw/rtl/ccint_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ccint_div.sv
// Radix-2 restoring divider for the segment fraction, one quotient bit per cycle.
// Depends on ccint_pkg. Requires numer < denom, so the quotient fits FRAC_W bits.
module ccint_div
    import ccint_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(FRAC_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [FRAC_W-1:0] quot_reg;

    logic [DATA_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, 1'b0};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(FRAC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.numer;
            den_reg  <= req.denom;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits DATA_W bits
            rem_reg  <= ge ? DATA_W'(trial - {1'b0, den_reg}) : DATA_W'(trial);
            quot_reg <= {quot_reg[FRAC_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
